/* design/hpt_pkg.sv */
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

  // Number format and field widths
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned MAT_N     = 16;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POINT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DIR   = 2'd2;

  // Arithmetic widths: product, sum of three products, rounded row
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 3;
  localparam int unsigned ROW_W  = SUM_W - FRAC_BITS;

  // Divider: quotient bits kept before saturation, and its latency
  localparam int unsigned Q_BITS  = DATA_W + 1;
  localparam int unsigned DIV_LAT = Q_BITS + 3;

  // 1.0 in the fixed-point format
  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Side information that runs alongside the divider
  typedef struct packed {
    logic                     point;
    logic                     fault;
    logic                     dir_ovf;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
  } side_t;

endpackage

/* design/hpt_if.sv */
// Request and result channel interfaces for the homogeneous point transform.
interface hpt_in_if;
  import hpt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [IDX_W-1:0]         element_index;
  logic signed [DATA_W-1:0] element_value;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] point_z;

  modport source (output valid, action, element_index, element_value,
                  point_x, point_y, point_z, input ready);
  modport sink   (input valid, action, element_index, element_value,
                  point_x, point_y, point_z, output ready);
endinterface

interface hpt_out_if;
  import hpt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic                     divide_fault;
  logic                     overflow_flag;

  modport source (output valid, out_x, out_y, out_z, divide_fault, overflow_flag,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, divide_fault, overflow_flag,
                  output ready);
endinterface

/* design/hpt_div.sv */
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), saturated to 32 bits.
module hpt_div
  import hpt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [ROW_W-1:0]  num_i,
  input  logic signed [ROW_W-1:0]  den_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] quot_o,
  output logic                     ovf_o
);

  localparam int unsigned SH    = Q_BITS - FRAC_BITS;
  localparam int unsigned CMP_W = ROW_W + SH;

  // Sign and magnitudes
  logic             a_valid_q, a_neg_q;
  logic [ROW_W-1:0] a_num_q, a_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_neg_q <= num_i[ROW_W-1] ^ den_i[ROW_W-1];
      a_num_q <= num_i[ROW_W-1] ? ROW_W'(-num_i) : ROW_W'(num_i);
      a_den_q <= den_i[ROW_W-1] ? ROW_W'(-den_i) : ROW_W'(den_i);
    end
  end

  // Iteration registers; index 0 is the setup stage
  logic             v_q   [Q_BITS+1];
  logic             neg_q [Q_BITS+1];
  logic             big_q [Q_BITS+1];
  logic [ROW_W-1:0] num_q [Q_BITS+1];
  logic [ROW_W-1:0] den_q [Q_BITS+1];
  logic [ROW_W-1:0] rem_q [Q_BITS+1];
  logic [Q_BITS-1:0] quo_q [Q_BITS+1];

  // Setup: early saturation test and leading remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= a_neg_q;
      big_q[0] <= CMP_W'(a_num_q) >= (CMP_W'(a_den_q) << SH);
      num_q[0] <= a_num_q;
      den_q[0] <= a_den_q;
      rem_q[0] <= a_num_q >> SH;
      quo_q[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < Q_BITS; j++) begin : g_iter
    localparam int unsigned B = Q_BITS - 1 - j;
    logic             dbit;
    logic [ROW_W:0]   trial;
    logic             take;

    if (B >= FRAC_BITS) begin : g_bit
      assign dbit = num_q[j][B-FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign trial = {rem_q[j], dbit};
    assign take  = trial >= {1'b0, den_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[j+1] <= neg_q[j];
        big_q[j+1] <= big_q[j];
        num_q[j+1] <= num_q[j];
        den_q[j+1] <= den_q[j];
        rem_q[j+1] <= take ? ROW_W'(trial - {1'b0, den_q[j]}) : ROW_W'(trial);
        quo_q[j+1] <= {quo_q[j][Q_BITS-2:0], take};
      end
    end
  end

  // Round half away from zero, apply sign, saturate
  logic                     rnd;
  logic [Q_BITS:0]          qr;
  logic                     sat;
  logic signed [DATA_W-1:0] res;
  logic                     fin_valid_q, fin_ovf_q;
  logic signed [DATA_W-1:0] fin_quot_q;

  always_comb begin
    rnd = {rem_q[Q_BITS], 1'b0} >= {1'b0, den_q[Q_BITS]};
    qr  = {1'b0, quo_q[Q_BITS]} + (Q_BITS+1)'(rnd);
    if (neg_q[Q_BITS]) begin
      sat = big_q[Q_BITS] || (qr > (Q_BITS+1)'({1'b0, S32_MIN}));
      res = sat ? S32_MIN : DATA_W'(-qr);
    end else begin
      sat = big_q[Q_BITS] || (qr > (Q_BITS+1)'(S32_MAX));
      res = sat ? S32_MAX : DATA_W'(qr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en_i) begin
      fin_valid_q <= v_q[Q_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fin_quot_q <= res;
      fin_ovf_q  <= sat;
    end
  end

  assign valid_o = fin_valid_q;
  assign quot_o  = fin_quot_q;
  assign ovf_o   = fin_ovf_q;

endmodule

/* design/homogeneous_point_transform.sv */
// Top level: 4x4 matrix store, multiply and row stages, perspective divide.
//
//  channel   | dir | handshake    | carries
//  ----------+-----+--------------+---------------------------------------------
//  point_i   | in  | valid/ready  | action, element index/value, point x/y/z
//  result_o  | out | valid/ready  | out x/y/z, divide_fault, overflow_flag
//
// One request per cycle is taken unless the pipeline holds; each result passes
// stages 1 to 3 and then the one-bit-per-stage divider. Loads write the matrix at
// acceptance and give no result. Reset loads the identity matrix and empties the
// pipeline. When the result is not taken the whole pipeline holds, and ready
// stays high while the output register is empty or being drained.
module homogeneous_point_transform
  import hpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hpt_in_if.sink    point_i,
  hpt_out_if.source result_o
);

  logic en;
  logic acc;

  assign en            = !result_o.valid || result_o.ready;
  assign point_i.ready = en;
  assign acc           = point_i.valid && en;

  // Matrix store, reset to identity
  logic signed [DATA_W-1:0] mat_q [MAT_N];

  for (genvar i = 0; i < MAT_N; i++) begin : g_mat
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mat_q[i] <= (i % 5 == 0) ? FX_ONE : '0;
      end else if (acc && point_i.action == ACT_LOAD &&
                   point_i.element_index == IDX_W'(i)) begin
        mat_q[i] <= point_i.element_value;
      end
    end
  end

  // Stage 1: capture the request and a matrix snapshot
  logic                     s1_valid_q, s1_point_q;
  logic signed [DATA_W-1:0] s1_v_q [3];
  logic signed [DATA_W-1:0] s1_m_q [MAT_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc && (point_i.action == ACT_POINT || point_i.action == ACT_DIR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_point_q <= point_i.action == ACT_POINT;
      s1_v_q[0]  <= point_i.point_x;
      s1_v_q[1]  <= point_i.point_y;
      s1_v_q[2]  <= point_i.point_z;
      for (int i = 0; i < MAT_N; i++) begin
        s1_m_q[i] <= mat_q[i];
      end
    end
  end

  // Stage 2: twelve products and the translation column
  logic                     s2_valid_q, s2_point_q;
  logic signed [PROD_W-1:0] s2_p_q [4][3];
  logic signed [DATA_W-1:0] s2_t_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_point_q <= s1_point_q;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          s2_p_q[r][k] <= s1_m_q[r*4+k] * s1_v_q[k];
        end
        s2_t_q[r] <= s1_point_q ? s1_m_q[r*4+3] : '0;
      end
    end
  end

  // Stage 3: sum, round to nearest (ties up), add translation
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic                    s3_valid_q, s3_point_q;
  logic signed [ROW_W-1:0] s3_row_q [4];
  logic signed [SUM_W-1:0] sum [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = SUM_W'(s2_p_q[r][0]) + SUM_W'(s2_p_q[r][1]) + SUM_W'(s2_p_q[r][2]) + HALF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_point_q <= s2_point_q;
      for (int r = 0; r < 4; r++) begin
        s3_row_q[r] <= ROW_W'(sum[r] >>> FRAC_BITS) + ROW_W'(s2_t_q[r]);
      end
    end
  end

  // Direction saturation and zero-divisor test, then side line to the divider
  side_t side_d;
  side_t side_q [DIV_LAT];
  logic  dsat [3];
  logic signed [DATA_W-1:0] dval [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s3_row_q[k] > ROW_W'(S32_MAX)) begin
        dsat[k] = 1'b1;
        dval[k] = S32_MAX;
      end else if (s3_row_q[k] < ROW_W'(S32_MIN)) begin
        dsat[k] = 1'b1;
        dval[k] = S32_MIN;
      end else begin
        dsat[k] = 1'b0;
        dval[k] = DATA_W'(s3_row_q[k]);
      end
    end
    side_d.point   = s3_point_q;
    side_d.fault   = s3_row_q[3] == '0;
    side_d.dir_ovf = dsat[0] || dsat[1] || dsat[2];
    side_d.dir_x   = dval[0];
    side_d.dir_y   = dval[1];
    side_d.dir_z   = dval[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Three divider lanes share the fourth row as divisor
  logic                     dv_valid [3];
  logic signed [DATA_W-1:0] dv_quot  [3];
  logic                     dv_ovf   [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    hpt_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s3_valid_q),
      .num_i   (s3_row_q[k]),
      .den_i   (s3_row_q[3]),
      .valid_o (dv_valid[k]),
      .quot_o  (dv_quot[k]),
      .ovf_o   (dv_ovf[k])
    );
  end

  // Result selection
  side_t so;
  assign so = side_q[DIV_LAT-1];
  assign result_o.valid = dv_valid[0] && dv_valid[1] && dv_valid[2];

  always_comb begin
    if (!so.point) begin
      result_o.out_x         = so.dir_x;
      result_o.out_y         = so.dir_y;
      result_o.out_z         = so.dir_z;
      result_o.divide_fault  = 1'b0;
      result_o.overflow_flag = so.dir_ovf;
    end else if (so.fault) begin
      result_o.out_x         = '0;
      result_o.out_y         = '0;
      result_o.out_z         = '0;
      result_o.divide_fault  = 1'b1;
      result_o.overflow_flag = 1'b0;
    end else begin
      result_o.out_x         = dv_quot[0];
      result_o.out_y         = dv_quot[1];
      result_o.out_z         = dv_quot[2];
      result_o.divide_fault  = 1'b0;
      result_o.overflow_flag = dv_ovf[0] || dv_ovf[1] || dv_ovf[2];
    end
  end

endmodule

/* tb/hpt_tb_if.sv */
// Testbench package: request and result records for the stimulus and expected queues.
package hpt_tb_pkg;
  import hpt_pkg::*;

  // One request as the stimulus queue holds it
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
  } req_t;

  // One transformed vertex
  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     divide_fault;
    logic                     overflow_flag;
  } vtx_t;
endpackage

/* tb/homogeneous_point_transform_test.sv */
// Self-checking testbench for the homogeneous point transform.
module homogeneous_point_transform_test;
  import hpt_pkg::*;
  import hpt_tb_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam int LIMIT = 400000;
  localparam longint ONE_L = longint'(1) <<< FRAC_BITS;
  localparam int HOLD_LEN = 300;

  logic clk_i, rst_ni;
  hpt_in_if  req_if ();
  hpt_out_if res_if ();

  homogeneous_point_transform u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .point_i(req_if.sink), .result_o(res_if.source)
  );

  req_t   pending_reqs[$];
  vtx_t   expected_vtx[$];
  longint mat[16] = '{0: ONE_L, 5: ONE_L, 10: ONE_L, 15: ONE_L, default: 0};
  int     send_idle, recv_idle;     // percent of cycles idle
  bit     hold_start;               // stimulus asks for the long receiver stall
  bit     hold_on;                  // long receiver stall in progress
  bit     pause_send;
  int     errors = 0;
  int     cycles = 0;
  int     n_points = 0;
  int     n_dirs = 0;
  int     n_faults = 0;
  int     n_ovf = 0;
  int     n_seen = 0;

  // Clock and reset
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
  end

  function automatic longint fl_shift(longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-(v + 1)) >>> FRAC_BITS) - 1;
  endfunction

  // Rounded row dot product, exact before rounding
  function automatic longint row_sum(int row, longint x, longint y, longint z, bit with_t);
    longint v[3];
    longint hi, lo, p, h;
    v[0] = x; v[1] = y; v[2] = z;
    hi = 0; lo = 0;
    for (int k = 0; k < 3; k++) begin
      p  = mat[row*4+k] * v[k];
      h  = fl_shift(p);
      hi += h;
      lo += p - (h <<< FRAC_BITS);
    end
    if (with_t) hi += mat[row*4+3];
    lo += longint'(1) <<< (FRAC_BITS - 1);
    return hi + (lo >>> FRAC_BITS);
  endfunction

  function automatic longint clamp32(longint v, ref bit ov);
    if (v > 64'sd2147483647) begin ov = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin ov = 1; return -64'sd2147483648; end
    return v;
  endfunction

  // Rounded perspective quotient, clamped well past 32 bits then saturated
  function automatic longint persp_div(longint n, longint w, ref bit ov);
    bit neg;
    logic [127:0] nm, dm, q, r;
    neg = (n < 0) != (w < 0);
    nm = (n < 0) ? -n : n;
    dm = (w < 0) ? -w : w;
    nm = nm << FRAC_BITS;
    q  = nm / dm;
    r  = nm % dm;
    if (q <= (128'd1 << 40) && r >= dm - r) q++;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return clamp32(neg ? -longint'(q) : longint'(q), ov);
  endfunction

  // Apply one request to the matrix copy and queue its result, if it has one
  task automatic predict(req_t rq);
    vtx_t   e;
    longint x, y, z, w, r[3];
    bit     ov;
    x = rq.point_x; y = rq.point_y; z = rq.point_z;
    ov = 0;
    e = '0;
    case (rq.action)
      ACT_LOAD: mat[rq.element_index] = rq.element_value;
      ACT_POINT: begin
        w = row_sum(3, x, y, z, 1);
        for (int k = 0; k < 3; k++) r[k] = row_sum(k, x, y, z, 1);
        if (w == 0) begin
          e.divide_fault = 1;
          r[0] = 0; r[1] = 0; r[2] = 0;
        end else begin
          for (int k = 0; k < 3; k++) r[k] = persp_div(r[k], w, ov);
        end
      end
      ACT_DIR: for (int k = 0; k < 3; k++) r[k] = clamp32(row_sum(k, x, y, z, 0), ov);
      default: ;
    endcase
    if (rq.action == ACT_POINT || rq.action == ACT_DIR) begin
      e.out_x = DATA_W'(r[0]); e.out_y = DATA_W'(r[1]); e.out_z = DATA_W'(r[2]);
      e.overflow_flag = ov;
      expected_vtx.push_back(e);
      if (rq.action == ACT_POINT) n_points++; else n_dirs++;
      if (e.divide_fault) n_faults++;
      if (ov) n_ovf++;
    end
  endtask

  // Field value with a bias towards the edges and small numbers
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
      3, 4, 5: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t mk(logic [ACT_W-1:0] a, logic [3:0] idx, logic [31:0] v,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z);
    req_t rq;
    rq.action = a; rq.element_index = idx; rq.element_value = v;
    rq.point_x = x; rq.point_y = y; rq.point_z = z;
    return rq;
  endfunction

  function automatic req_t rnd_req();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12)
      return mk(ACT_LOAD, 4'($urandom()), rnd_val(), $urandom(), $urandom(), $urandom());
    if (sel < 14)
      return mk(ACT_NONE, 4'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
    return mk(sel < 60 ? ACT_POINT : ACT_DIR, 4'($urandom()), $urandom(),
              rnd_val(), rnd_val(), rnd_val());
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_vtx.size() != 0) @(posedge clk_i);
  endtask

  // Driver: requests are predicted as they are accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid         <= 0;
      req_if.action        <= ACT_LOAD;
      req_if.element_index <= '0;
      req_if.element_value <= '0;
      req_if.point_x       <= '0;
      req_if.point_y       <= '0;
      req_if.point_z       <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict(pending_reqs.pop_front());
      end
      if (pending_reqs.size() != 0 && !pause_send &&
          ((req_if.valid && !req_if.ready) || $urandom_range(0, 99) >= send_idle)) begin
        req_if.valid         <= 1;
        req_if.action        <= pending_reqs[0].action;
        req_if.element_index <= pending_reqs[0].element_index;
        req_if.element_value <= pending_reqs[0].element_value;
        req_if.point_x       <= pending_reqs[0].point_x;
        req_if.point_y       <= pending_reqs[0].point_y;
        req_if.point_z       <= pending_reqs[0].point_z;
      end else begin
        req_if.valid <= 0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles once the stimulus asks for it
  initial begin
    hold_on = 0;
    wait (hold_start);
    @(posedge clk_i);
    hold_on = 1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_on = 0;
  end

  // Monitor: receiver stalls and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_seen++;
        if (expected_vtx.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          vtx_t e;
          e = expected_vtx.pop_front();
          if (res_if.out_x !== e.out_x) begin
            $error("out_x exp %h got %h", e.out_x, res_if.out_x); errors++;
          end
          if (res_if.out_y !== e.out_y) begin
            $error("out_y exp %h got %h", e.out_y, res_if.out_y); errors++;
          end
          if (res_if.out_z !== e.out_z) begin
            $error("out_z exp %h got %h", e.out_z, res_if.out_z); errors++;
          end
          if (res_if.divide_fault !== e.divide_fault) begin
            $error("divide_fault exp %b got %b", e.divide_fault, res_if.divide_fault);
            errors++;
          end
          if (res_if.overflow_flag !== e.overflow_flag) begin
            $error("overflow_flag exp %b got %b", e.overflow_flag, res_if.overflow_flag);
            errors++;
          end
        end
      end
      if (hold_on) begin
        res_if.ready <= 0;
      end else begin
        res_if.ready <= $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    pause_send = 0;
    send_idle = 13; recv_idle = 60;
    @(posedge rst_ni);

    // Directed: identity, extremes, unused code, zero divisor, overflow, scale
    pending_reqs.push_back(mk(ACT_POINT, 0, 0, 32'h0001_8000, 32'hFFFF_0000, 32'h7FFF_FFFF));
    pending_reqs.push_back(mk(ACT_DIR, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
    pending_reqs.push_back(mk(ACT_POINT, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_reqs.push_back(mk(ACT_NONE, 4'hF, 0, 1, 2, 3));
    pending_reqs.push_back(mk(ACT_LOAD, 15, 0, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_POINT, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    pending_reqs.push_back(mk(ACT_LOAD, 15, 32'h0000_0001, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_POINT, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000));
    pending_reqs.push_back(mk(ACT_LOAD, 15, 32'h0001_0000, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_LOAD, 0, 32'h7FFF_FFFF, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_LOAD, 3, 32'h8000_0000, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_LOAD, 14, 32'h0000_8000, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_POINT, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000));
    pending_reqs.push_back(mk(ACT_DIR, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(ACT_POINT, 0, 0, 32'h0000_0000, 32'h0000_0000, 32'hFFFE_0000));
    pending_reqs.push_back(mk(ACT_LOAD, 0, 32'h0001_0000, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_LOAD, 3, 32'h0000_0000, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_LOAD, 14, 32'h0000_0000, 0, 0, 0));
    wait_drained();

    // Three idling phases of random traffic
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 13 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 13 : 0;
      for (int i = 0; i < 520; i++) pending_reqs.push_back(rnd_req());
      if (ph == 2) hold_start = 1;   // block fills up while sender keeps offering
      wait_drained();
      pause_send = 1;                // quiet gap with everything delivered
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
      pause_send = 0;
    end

    repeat (60) @(posedge clk_i);
    $display("%0d points (%0d divide faults) and %0d directions checked, %0d saturated;",
             n_points, n_faults, n_dirs, n_ovf);
    $display("%0d results seen under three stall patterns and a long output hold-off", n_seen);
    if (errors == 0 && expected_vtx.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/hpt_pkg.sv
design/hpt_if.sv
design/hpt_div.sv
design/homogeneous_point_transform.sv
tb/hpt_tb_if.sv
tb/homogeneous_point_transform_test.sv
